FILE: rtl/core/fwsd_pkg.sv
// fwsd_pkg: shared constants, tables and types of the four wheel steer duty mapper
// no dependencies
package fwsd_pkg;

  localparam int unsigned PREP_N     = 5;
  localparam int unsigned SQ_N       = 30;
  localparam int unsigned DIV_N      = 31;
  localparam int unsigned DUTY_N     = 14;
  localparam int unsigned CORDIC_N   = 22;
  localparam int unsigned CORDIC_LAT = CORDIC_N + 1;
  localparam int unsigned WHEEL_LAT  = PREP_N + SQ_N + DIV_N + DUTY_N;

  localparam logic [22:0] ATAN_Q16 [CORDIC_N] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2
  };

  localparam logic [63:0] POLY_C0    = 64'd4024200 << 30;
  localparam logic [63:0] POLY_SCALE = 64'd1000000 << 30;
  localparam logic [26:0] DUTY_UNIT  = 27'd1000000;
  localparam logic [18:0] RATE_CLAMP = 19'd262144;

  typedef enum logic [2:0] {
    CFG_WHEEL_RADIUS = 3'd0,
    CFG_FRONT_LEN    = 3'd1,
    CFG_REAR_LEN     = 3'd2,
    CFG_TRACK        = 3'd3,
    CFG_MIN_DUTY     = 3'd4,
    CFG_MAX_DUTY     = 3'd5,
    CFG_MAX_STEER    = 3'd6,
    CFG_SPIN_DUTY    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic on;
    logic wneg;
  } ang_ctl_t;

endpackage

FILE: rtl/core/four_wheel_steer_duty_mapper_unit.sv
// four_wheel_steer_duty_mapper_unit: top level, configuration registers,
// geometry front end, wheel lanes, angle alignment and output register
// depends on fwsd_pkg, fwsd_cordic, fwsd_isqrt, fwsd_div, fwsd_duty
//
// Maps a drive word (forward speed, turn rate, both signed Q8.8) to four signed
// wheel duties and a steering angle. One word is accepted per clock while the
// output is not held; the wheel lane sets the path of a result: five geometry
// stages, a 30 stage square root, a 31 stage divider by the wheel radius, a 14
// stage polynomial and the output register. The steering cordic runs in
// parallel and is delayed to match. When the output is held the whole pipeline
// holds. Configuration writes take effect at once; the user must make them only
// while no word is in flight, which the block itself does not enforce.
module four_wheel_steer_duty_mapper_unit import fwsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // forward_speed, turn_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // duty_front_left, duty_front_right,
                                     // duty_rear_left, duty_rear_right, steer_angle
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i
);

  typedef struct packed {
    logic v0;
    logic w0;
    logic vneg;
    logic wneg;
  } flg_t;

  localparam int unsigned ANG_DLY = WHEEL_LAT - 2 - CORDIC_LAT;

  logic [9:0]  wr_q;
  logic [11:0] lf_q, lr_q, tw_q;
  logic [6:0]  min_q, max_q, steer_q, spin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 10'd127;
      lf_q    <= 12'd400;
      lr_q    <= 12'd450;
      tw_q    <= 12'd625;
      min_q   <= 7'd8;
      max_q   <= 7'd80;
      steer_q <= 7'd25;
      spin_q  <= 7'd11;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WHEEL_RADIUS: wr_q    <= cfg_wdata_i[9:0];
        CFG_FRONT_LEN:    lf_q    <= cfg_wdata_i;
        CFG_REAR_LEN:     lr_q    <= cfg_wdata_i;
        CFG_TRACK:        tw_q    <= cfg_wdata_i;
        CFG_MIN_DUTY:     min_q   <= cfg_wdata_i[6:0];
        CFG_MAX_DUTY:     max_q   <= cfg_wdata_i[6:0];
        CFG_MAX_STEER:    steer_q <= cfg_wdata_i[6:0];
        CFG_SPIN_DUTY:    spin_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic vld_q [WHEEL_LAT+1];

  assign adv           = !vld_q[WHEEL_LAT] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[WHEEL_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= WHEEL_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k <= WHEEL_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // geometry front end
  logic [15:0]        av_q, aw_q;
  flg_t               flg_q [WHEEL_LAT];
  logic [28:0]        af_q, ar_q, awlen_q;
  logic [25:0]        bv_q;
  logic [27:0]        t_q;
  logic [28:0]        af3_q, ar3_q;
  logic signed [29:0] bl_q, br_q;
  logic [57:0]        afsq_q, arsq_q, blsq_q, brsq_q;
  logic [59:0]        sq_q [4];
  logic [12:0]        len;

  assign len = 13'(lf_q) + 13'(lr_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      av_q <= s_axis_tdata[15] ? 16'(~s_axis_tdata[15:0] + 16'd1) : s_axis_tdata[15:0];
      aw_q <= s_axis_tdata[31] ? 16'(~s_axis_tdata[31:16] + 16'd1) : s_axis_tdata[31:16];
      flg_q[0].v0   <= (s_axis_tdata[15:0] == '0);
      flg_q[0].w0   <= (s_axis_tdata[31:16] == '0);
      flg_q[0].vneg <= s_axis_tdata[15];
      flg_q[0].wneg <= s_axis_tdata[31];
      for (int k = 1; k < WHEEL_LAT; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      af_q    <= {28'(aw_q) * 28'(lf_q), 1'b0};
      ar_q    <= {28'(aw_q) * 28'(lr_q), 1'b0};
      bv_q    <= 26'(av_q) * 26'd2000;
      t_q     <= 28'(aw_q) * 28'(tw_q);
      awlen_q <= 29'(aw_q) * 29'(len);
      af3_q   <= af_q;
      ar3_q   <= ar_q;
      if (!flg_q[1].wneg) begin
        bl_q <= $signed({4'd0, bv_q}) + $signed({2'd0, t_q});
        br_q <= $signed({4'd0, bv_q}) - $signed({2'd0, t_q});
      end else begin
        bl_q <= $signed({4'd0, bv_q}) - $signed({2'd0, t_q});
        br_q <= $signed({4'd0, bv_q}) + $signed({2'd0, t_q});
      end
      afsq_q <= 58'(af3_q) * 58'(af3_q);
      arsq_q <= 58'(ar3_q) * 58'(ar3_q);
      blsq_q <= 58'(bl_q) * 58'(bl_q);
      brsq_q <= 58'(br_q) * 58'(br_q);
      sq_q[0] <= 60'(afsq_q) + 60'(blsq_q);
      sq_q[1] <= 60'(afsq_q) + 60'(brsq_q);
      sq_q[2] <= 60'(arsq_q) + 60'(blsq_q);
      sq_q[3] <= 60'(arsq_q) + 60'(brsq_q);
    end
  end

  // steering angle lane
  ang_ctl_t          actl;
  logic signed [7:0] ang_c;
  logic signed [7:0] ang_q [ANG_DLY];

  assign actl.on   = !flg_q[1].w0 && (len != '0);
  assign actl.wneg = flg_q[1].wneg;

  fwsd_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .x_i         ($signed({6'd0, bv_q, 16'd0})),
    .y_i         ($signed({3'd0, awlen_q, 16'd0})),
    .ctl_i       (actl),
    .max_steer_i (steer_q),
    .angle_o     (ang_c)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0] <= ang_c;
      for (int k = 1; k < ANG_DLY; k++) begin
        ang_q[k] <= ang_q[k-1];
      end
    end
  end

  // wheel lanes
  logic [9:0]        rw;
  logic signed [7:0] duty [4];

  assign rw = (wr_q == '0) ? 10'd1 : wr_q;

  for (genvar k = 0; k < 4; k++) begin : g_whl
    logic [29:0] root;
    logic [30:0] quo;
    logic        zero;

    fwsd_isqrt u_isqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .rad_i  (sq_q[k]),
      .root_o (root)
    );

    fwsd_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .num_i  ({root, 1'b0}),
      .den_i  (rw),
      .quo_o  (quo),
      .zero_o (zero)
    );

    fwsd_duty u_duty (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .rate_i     (quo),
      .zero_i     (zero),
      .min_duty_i (min_q),
      .max_duty_i (max_q),
      .duty_o     (duty[k])
    );
  end

  // output register
  flg_t              fo;
  logic [39:0]       out_d, out_q;
  logic signed [7:0] spin_s, steer_s;

  assign fo      = flg_q[WHEEL_LAT-1];
  assign spin_s  = $signed({1'b0, spin_q});
  assign steer_s = $signed({1'b0, steer_q});

  always_comb begin
    if (fo.v0) begin
      if (fo.w0) begin
        out_d = '0;
      end else begin
        out_d = {fo.wneg ? -steer_s : steer_s, spin_s, spin_s, spin_s, spin_s};
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        out_d[8*k +: 8] = fo.vneg ? -duty[k] : duty[k];
      end
      out_d[39:32] = ang_q[ANG_DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule

FILE: rtl/core/fwsd_cordic.sv
// fwsd_cordic: pipelined cordic vectoring, steering angle in whole degrees
// depends on fwsd_pkg
module fwsd_cordic import fwsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic signed [47:0] x_i,
  input  logic signed [47:0] y_i,
  input  ang_ctl_t           ctl_i,
  input  logic [6:0]         max_steer_i,
  output logic signed [7:0]  angle_o
);

  logic signed [47:0] x_w [CORDIC_N+1];
  logic signed [47:0] y_w [CORDIC_N+1];
  logic signed [24:0] z_w [CORDIC_N+1];
  ang_ctl_t           c_w [CORDIC_N+1];

  assign x_w[0] = x_i;
  assign y_w[0] = y_i;
  assign z_w[0] = '0;
  assign c_w[0] = ctl_i;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_st
    logic signed [47:0] x_q, y_q, x_d, y_d, xs, ay;
    logic signed [24:0] z_q, z_d;
    ang_ctl_t           c_q;

    always_comb begin
      xs  = x_w[i] >>> i;
      ay  = y_w[i][47] ? -y_w[i] : y_w[i];
      x_d = x_w[i] + (ay >>> i);
      if (!y_w[i][47]) begin
        y_d = y_w[i] - xs;
        z_d = z_w[i] + $signed({2'b00, ATAN_Q16[i]});
      end else begin
        y_d = y_w[i] + xs;
        z_d = z_w[i] - $signed({2'b00, ATAN_Q16[i]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        c_q <= c_w[i];
      end
    end

    assign x_w[i+1] = x_q;
    assign y_w[i+1] = y_q;
    assign z_w[i+1] = z_q;
    assign c_w[i+1] = c_q;
  end

  logic [6:0]        deg;
  logic signed [7:0] angle_d, angle_q;

  always_comb begin
    deg = z_w[CORDIC_N][24] ? 7'd0 : z_w[CORDIC_N][22:16];
    if (deg > max_steer_i) begin
      deg = max_steer_i;
    end
    if (!c_w[CORDIC_N].on) begin
      angle_d = '0;
    end else if (c_w[CORDIC_N].wneg) begin
      angle_d = -$signed({1'b0, deg});
    end else begin
      angle_d = $signed({1'b0, deg});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

FILE: rtl/core/fwsd_isqrt.sv
// fwsd_isqrt: pipelined integer square root, two radicand bits per stage
// depends on fwsd_pkg
module fwsd_isqrt import fwsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [59:0] rad_i,
  output logic [29:0] root_o
);

  logic [59:0] rad_w  [SQ_N+1];
  logic [31:0] rem_w  [SQ_N+1];
  logic [29:0] root_w [SQ_N+1];

  assign rad_w[0]  = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar s = 0; s < SQ_N; s++) begin : g_st
    logic [59:0] rad_q;
    logic [31:0] rem_q, rem_d;
    logic [29:0] root_q, root_d;
    logic [32:0] cur, trial;

    always_comb begin
      cur   = {rem_w[s][30:0], rad_w[s][59:58]};
      trial = {1'b0, root_w[s], 2'b01};
      if (cur >= trial) begin
        rem_d  = 32'(cur - trial);
        root_d = {root_w[s][28:0], 1'b1};
      end else begin
        rem_d  = cur[31:0];
        root_d = {root_w[s][28:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rad_q  <= {rad_w[s][57:0], 2'b00};
        rem_q  <= rem_d;
        root_q <= root_d;
      end
    end

    assign rad_w[s+1]  = rad_q;
    assign rem_w[s+1]  = rem_q;
    assign root_w[s+1] = root_q;
  end

  assign root_o = root_w[SQ_N];

endmodule

FILE: rtl/core/fwsd_div.sv
// fwsd_div: pipelined restoring divider, one quotient bit per stage
// depends on fwsd_pkg
module fwsd_div import fwsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [30:0] num_i,
  input  logic [9:0]  den_i,
  output logic [30:0] quo_o,
  output logic        zero_o
);

  logic [30:0] num_w [DIV_N+1];
  logic [9:0]  rem_w [DIV_N+1];
  logic [30:0] quo_w [DIV_N+1];
  logic        zer_w [DIV_N+1];

  assign num_w[0] = num_i;
  assign rem_w[0] = '0;
  assign quo_w[0] = '0;
  assign zer_w[0] = (num_i == '0);

  for (genvar s = 0; s < DIV_N; s++) begin : g_st
    logic [30:0] num_q, quo_q, quo_d;
    logic [9:0]  rem_q, rem_d;
    logic        zer_q;
    logic [10:0] cur;

    always_comb begin
      cur = {rem_w[s], num_w[s][30]};
      if (cur >= {1'b0, den_i}) begin
        rem_d = 10'(cur - {1'b0, den_i});
        quo_d = {quo_w[s][29:0], 1'b1};
      end else begin
        rem_d = cur[9:0];
        quo_d = {quo_w[s][29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        num_q <= {num_w[s][29:0], 1'b0};
        rem_q <= rem_d;
        quo_q <= quo_d;
        zer_q <= zer_w[s];
      end
    end

    assign num_w[s+1] = num_q;
    assign rem_w[s+1] = rem_q;
    assign quo_w[s+1] = quo_q;
    assign zer_w[s+1] = zer_q;
  end

  assign quo_o  = quo_w[DIV_N];
  assign zero_o = zer_w[DIV_N];

endmodule

FILE: rtl/core/fwsd_duty.sv
// fwsd_duty: pipelined cubic rate-to-duty polynomial with dead zone and saturation
// depends on fwsd_pkg
module fwsd_duty import fwsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [30:0]       rate_i,
  input  logic              zero_i,
  input  logic [6:0]        min_duty_i,
  input  logic [6:0]        max_duty_i,
  output logic signed [7:0] duty_o
);

  typedef struct packed {
    logic zero;
    logic neg;
    logic lo;
    logic hi;
  } duty_ctl_t;

  localparam int unsigned QN = 7;

  logic [18:0] r1_q, r2_r_q;
  logic [37:0] r2_q;
  logic [56:0] r3_q;
  logic [39:0] p1_q;
  logic [49:0] p2_q;
  logic [63:0] pos_q, neg_q, mag_q;
  logic        z1_q, z2_q, z3_q, z4_q, z5_q, ng5_q;
  duty_ctl_t   c6_q;
  logic [26:0] x6_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r1_q   <= (rate_i > 31'(RATE_CLAMP)) ? RATE_CLAMP : rate_i[18:0];
      z1_q   <= zero_i;
      r2_q   <= 38'(r1_q) * 38'(r1_q);
      r2_r_q <= r1_q;
      z2_q   <= z1_q;
      r3_q   <= 57'(r2_q) * 57'(r2_r_q);
      p1_q   <= 40'(r2_r_q) * 40'd1842400;
      p2_q   <= 50'(r2_q) * 50'd15540;
      z3_q   <= z2_q;
      pos_q  <= POLY_C0 + {4'd0, p1_q, 20'd0} + {4'd0, p2_q, 10'd0};
      neg_q  <= 64'(r3_q) * 64'd216;
      z4_q   <= z3_q;
      ng5_q  <= neg_q > pos_q;
      mag_q  <= (neg_q > pos_q) ? neg_q - pos_q : pos_q - neg_q;
      z5_q   <= z4_q;
      c6_q.zero <= z5_q;
      c6_q.neg  <= ng5_q;
      c6_q.lo   <= mag_q < 64'(min_duty_i) * POLY_SCALE;
      c6_q.hi   <= mag_q > 64'(max_duty_i) * POLY_SCALE;
      x6_q      <= mag_q[56:30];
    end
  end

  logic [26:0] rem_w [QN+1];
  logic [6:0]  quo_w [QN+1];
  duty_ctl_t   ctl_w [QN+1];

  assign rem_w[0] = x6_q;
  assign quo_w[0] = '0;
  assign ctl_w[0] = c6_q;

  for (genvar j = 0; j < QN; j++) begin : g_q
    localparam logic [26:0] THR = DUTY_UNIT << (QN - 1 - j);
    logic [26:0] rem_q;
    logic [6:0]  quo_q;
    duty_ctl_t   ctl_q;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (rem_w[j] >= THR) begin
          rem_q <= rem_w[j] - THR;
          quo_q <= quo_w[j] | 7'(1 << (QN - 1 - j));
        end else begin
          rem_q <= rem_w[j];
          quo_q <= quo_w[j];
        end
        ctl_q <= ctl_w[j];
      end
    end

    assign rem_w[j+1] = rem_q;
    assign quo_w[j+1] = quo_q;
    assign ctl_w[j+1] = ctl_q;
  end

  logic [6:0]        dm;
  logic signed [7:0] duty_d, duty_q;

  always_comb begin
    if (ctl_w[QN].lo) begin
      dm = '0;
    end else if (ctl_w[QN].hi) begin
      dm = max_duty_i;
    end else begin
      dm = quo_w[QN];
    end
    if (ctl_w[QN].zero) begin
      duty_d = '0;
    end else if (ctl_w[QN].neg) begin
      duty_d = -$signed({1'b0, dm});
    end else begin
      duty_d = $signed({1'b0, dm});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule
